// ===== sv/htfi_pkg.sv =====
package htfi_pkg;

  localparam int unsigned HT_SLOTS = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned OCC_W    = 7;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_ZERO_KEY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE
  } ctrl_state_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] new_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    status_e             status;
    logic [OCC_W-1:0]    occupied;
  } res_t;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    mod_step;
    logic    issue;
    logic    finish;
    status_e fin_code;
  } cmd_t;

  typedef struct packed {
    logic in_key_zero;
    logic mod_needed;
    logic mod_last;
    logic hit;
    logic empty;
    logic last;
    logic issue_ok;
    logic clear_last;
  } sts_t;

endpackage

// ===== sv/hash_table_find_or_insert_unit.sv =====
// Find-or-insert unit for an open-addressing hash table with triangular
// probing. A request beat (key, new_handle on req_i) is taken at a clock edge
// where start_i is high and busy_o is low. Exactly one result beat follows on
// res_o, marked by done_o for one cycle; the receiver must take it then, as
// it cannot stall the unit. Results are: found (stored handle), inserted (new
// handle stored in the first empty slot), table full, or zero key.
// A zero key answers in the cycle right after acceptance. Otherwise a request
// first takes a remainder step when SLOTS is not a power of two. The probe loop
// issues one key-memory read per cycle and compares the data read against the
// key and against zero in the cycle after the read is issued.
// One request is in flight at a time; busy_o drops on the cycle done_o rises,
// so the next request may be accepted while the result is shown.
// After reset the key memory is swept to zero, one slot per cycle, with busy_o
// high; the occupancy count restarts at zero.
module hash_table_find_or_insert_unit #(
  parameter int unsigned SLOTS = htfi_pkg::HT_SLOTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  htfi_pkg::req_t req_i,
  output logic           done_o,
  output htfi_pkg::res_t res_o
);

  htfi_pkg::cmd_t cmd;
  htfi_pkg::sts_t sts;

  htfi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  htfi_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

// ===== sv/htfi_ctrl.sv =====
module htfi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  htfi_pkg::sts_t        sts_i,
  output htfi_pkg::cmd_t        cmd_o,
  output logic                  busy_o
);

  htfi_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htfi_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htfi_pkg::S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = htfi_pkg::S_IDLE;
        end
      end
      htfi_pkg::S_IDLE: begin
        if (start_i && !sts_i.in_key_zero) begin
          state_d = sts_i.mod_needed ? htfi_pkg::S_MOD : htfi_pkg::S_PROBE;
        end
      end
      htfi_pkg::S_MOD: begin
        if (sts_i.mod_last) begin
          state_d = htfi_pkg::S_PROBE;
        end
      end
      htfi_pkg::S_PROBE: begin
        if (sts_i.hit || sts_i.empty || sts_i.last) begin
          state_d = htfi_pkg::S_IDLE;
        end
      end
      default: state_d = htfi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.fin_code = htfi_pkg::ST_FOUND;
    busy_o         = 1'b1;
    unique case (state_q)
      htfi_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      htfi_pkg::S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
        if (start_i && sts_i.in_key_zero) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_code = htfi_pkg::ST_ZERO_KEY;
        end
      end
      htfi_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
      end
      htfi_pkg::S_PROBE: begin
        // The compare stage works on the read issued in the previous cycle.
        priority if (sts_i.hit) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_code = htfi_pkg::ST_FOUND;
        end else if (sts_i.empty) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_code = htfi_pkg::ST_INSERTED;
        end else if (sts_i.last) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_code = htfi_pkg::ST_FULL;
        end else begin
          cmd_o.issue = sts_i.issue_ok;
        end
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/htfi_datapath.sv =====
module htfi_datapath #(
  parameter int unsigned SLOTS = htfi_pkg::HT_SLOTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  htfi_pkg::req_t req_i,
  input  htfi_pkg::cmd_t cmd_i,
  output htfi_pkg::sts_t sts_o,
  output logic           done_o,
  output htfi_pkg::res_t res_o
);

  localparam int unsigned IdxW    = $clog2(SLOTS);
  localparam int unsigned CntW    = $clog2(SLOTS + 1);
  localparam int unsigned SumW    = IdxW + 2;
  localparam int unsigned RemW    = IdxW + 1;
  localparam int unsigned RecSh   = IdxW + 31;
  localparam logic [31:0] RecM    = 32'((64'd1 << RecSh) / 64'(SLOTS));
  localparam int unsigned SlotExW = (IdxW > htfi_pkg::SLOT_W) ? IdxW : htfi_pkg::SLOT_W;
  localparam int unsigned OccExW  = (CntW > htfi_pkg::OCC_W) ? CntW : htfi_pkg::OCC_W;
  localparam bit          IsPow2  = ((SLOTS & (SLOTS - 1)) == 0);

  logic [htfi_pkg::KEY_W-1:0]    key_mem    [SLOTS];
  logic [htfi_pkg::HANDLE_W-1:0] handle_mem [SLOTS];

  logic [htfi_pkg::KEY_W-1:0]    key_q, key_rd_q;
  logic [htfi_pkg::HANDLE_W-1:0] handle_q, handle_rd_q;
  logic [IdxW-1:0]               pos_q, pos_nxt, rd_pos_q, clr_q;
  logic [CntW-1:0]               probe_q, rd_probe_q, fill_q, fill_inc;
  logic [RemW-1:0]               quot_q;
  logic                          mod_ph_q;
  logic                          rd_vld_q, done_q;
  htfi_pkg::res_t                res_q;

  logic [SumW-1:0]    pos_sum;
  logic [63:0]        mul_prod;
  logic [RemW-1:0]    rem_est, rem_fix;
  logic               ins_we, key_we;
  logic [IdxW-1:0]    key_waddr;
  logic [htfi_pkg::KEY_W-1:0] key_wdata;
  logic [SlotExW-1:0] slot_ext;
  logic [OccExW-1:0]  occ_ext;
  htfi_pkg::res_t     res_d;

  // Triangular step: the increment after probe i is i + 1, and the sum stays
  // below twice the slot count, so one conditional subtract wraps it.
  always_comb begin
    pos_sum = SumW'(pos_q) + SumW'(probe_q) + SumW'(1);
    if (pos_sum >= SumW'(SLOTS)) begin
      pos_sum = pos_sum - SumW'(SLOTS);
    end
    pos_nxt = pos_sum[IdxW-1:0];
  end

  // Home slot for slot counts that are not powers of two. The first step
  // takes a 32 by 32 product with the truncated reciprocal, whose quotient
  // is exact or one short. The second step forms the remainder on its low
  // bits and corrects it with a single conditional subtract.
  always_comb begin
    mul_prod = 64'(key_q) * 64'(RecM);
    rem_est  = key_q[RemW-1:0] - quot_q * RemW'(SLOTS);
    rem_fix  = rem_est;
    if (rem_est >= RemW'(SLOTS)) begin
      rem_fix = rem_est - RemW'(SLOTS);
    end
  end

  assign ins_we    = cmd_i.finish && (cmd_i.fin_code == htfi_pkg::ST_INSERTED);
  assign key_we    = cmd_i.clear || ins_we;
  assign key_waddr = cmd_i.clear ? clr_q : rd_pos_q;
  assign key_wdata = cmd_i.clear ? '0 : key_q;
  assign fill_inc  = fill_q + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (cmd_i.issue) begin
      key_rd_q <= key_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      handle_mem[rd_pos_q] <= handle_q;
    end
    if (cmd_i.issue) begin
      handle_rd_q <= handle_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q    <= req_i.key;
      handle_q <= req_i.new_handle;
    end
    if (cmd_i.mod_step && !mod_ph_q) begin
      quot_q <= mul_prod[RecSh +: RemW];
    end
    if (cmd_i.load) begin
      pos_q <= IsPow2 ? req_i.key[IdxW-1:0] : '0;
    end else if (cmd_i.mod_step && mod_ph_q) begin
      pos_q <= rem_fix[IdxW-1:0];
    end else if (cmd_i.issue) begin
      pos_q <= pos_nxt;
    end
    if (cmd_i.issue) begin
      rd_pos_q   <= pos_q;
      rd_probe_q <= probe_q;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q  <= '0;
      rd_vld_q <= 1'b0;
      mod_ph_q <= 1'b0;
      clr_q    <= '0;
      fill_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      done_q   <= cmd_i.finish;
      if (cmd_i.clear) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (cmd_i.load) begin
        probe_q  <= '0;
        mod_ph_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          probe_q <= probe_q + CntW'(1);
        end
        if (cmd_i.mod_step) begin
          mod_ph_q <= 1'b1;
        end
      end
      if (ins_we) begin
        fill_q <= fill_inc;
      end
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = cmd_i.fin_code;
    slot_ext     = '0;
    occ_ext      = OccExW'(fill_q);
    unique case (cmd_i.fin_code)
      htfi_pkg::ST_FOUND: begin
        res_d.handle = handle_rd_q;
        slot_ext     = SlotExW'(rd_pos_q);
      end
      htfi_pkg::ST_INSERTED: begin
        res_d.handle = handle_q;
        slot_ext     = SlotExW'(rd_pos_q);
        occ_ext      = OccExW'(fill_inc);
      end
      htfi_pkg::ST_FULL, htfi_pkg::ST_ZERO_KEY: begin
        res_d.handle = '0;
      end
      default: res_d.handle = '0;
    endcase
    res_d.slot     = slot_ext[htfi_pkg::SLOT_W-1:0];
    res_d.occupied = occ_ext[htfi_pkg::OCC_W-1:0];
  end

  assign sts_o.in_key_zero = (req_i.key == '0);
  assign sts_o.mod_needed  = !IsPow2;
  assign sts_o.mod_last    = mod_ph_q;
  assign sts_o.hit         = rd_vld_q && (key_rd_q == key_q);
  assign sts_o.empty       = rd_vld_q && (key_rd_q == '0);
  assign sts_o.last        = rd_vld_q && (rd_probe_q == CntW'(SLOTS - 1));
  assign sts_o.issue_ok    = (probe_q != CntW'(SLOTS));
  assign sts_o.clear_last  = (clr_q == IdxW'(SLOTS - 1));

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/htfi_checker.sv =====
module htfi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input htfi_pkg::req_t req_i,
  input logic           done_o,
  input htfi_pkg::res_t res_o
);

  // A zero key is answered on the very next cycle.
  a_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_i.key == '0)) |=>
      (done_o && (res_o.status == htfi_pkg::ST_ZERO_KEY)))
    else $error("zero key not answered next cycle");

  // A result beat only follows an accepted request or ongoing work.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result beat without a request");

  // Error results carry neither a handle nor a slot.
  a_err_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((res_o.status == htfi_pkg::ST_FULL) ||
                (res_o.status == htfi_pkg::ST_ZERO_KEY))) |->
      ((res_o.handle == '0) && (res_o.slot == '0)))
    else $error("error result with nonzero handle or slot");

  // After an insertion the table cannot be empty.
  a_ins_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == htfi_pkg::ST_INSERTED)) |-> (res_o.occupied != '0))
    else $error("insert reported with zero occupancy");

endmodule

bind hash_table_find_or_insert_unit htfi_checker u_htfi_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .res_o   (res_o)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RAND_ITEMS = 1780;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned N_DIRECTED = 17;

  typedef struct packed {
    htfi_pkg::req_t req;
    logic           typed;
    htfi_pkg::res_t want;
  } dir_row_t;

  // Rows with typed set carry a result that follows directly from the table
  // contents; the others are checked against the predictor.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{32'h0000_0000, 64'hDEAD_BEEF_0000_0001}, 1'b1,
      '{64'h0, 6'd0, htfi_pkg::ST_ZERO_KEY, 7'd0}},
    '{'{32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFF, 6'd1, htfi_pkg::ST_INSERTED, 7'd1}},
    '{'{32'h0000_0001, 64'h0000_0000_0000_0005}, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFF, 6'd1, htfi_pkg::ST_FOUND, 7'd1}},
    '{'{32'hFFFF_FFFF, 64'h0000_0000_0000_0000}, 1'b1,
      '{64'h0, 6'd63, htfi_pkg::ST_INSERTED, 7'd2}},
    '{'{32'hFFFF_FFFF, 64'h0000_0000_0000_007B}, 1'b1,
      '{64'h0, 6'd63, htfi_pkg::ST_FOUND, 7'd2}},
    '{'{32'h0000_0041, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
    '{'{32'h0000_0081, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
    '{'{32'h0000_00C1, 64'hFEDC_BA98_7654_3210}, 1'b0, '0},
    '{'{32'h8000_0000, 64'h0000_0000_0000_0001}, 1'b0, '0},
    '{'{32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{64'h0, 6'd0, htfi_pkg::ST_ZERO_KEY, 7'd6}},
    '{'{32'h0000_0041, 64'h0000_0000_0000_0000}, 1'b0, '0},
    '{'{32'h0000_00C1, 64'h1111_1111_1111_1111}, 1'b0, '0},
    '{'{32'h7FFF_FFFF, 64'h8000_0000_0000_0000}, 1'b0, '0},
    '{'{32'hAAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0, '0},
    '{'{32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
    '{'{32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF}, 1'b0, '0},
    '{'{32'h0000_0040, 64'h0000_0000_FFFF_FFFF}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  htfi_pkg::req_t req_i = '0;
  logic busy_o;
  logic done_o;
  htfi_pkg::res_t res_o;

  logic [htfi_pkg::KEY_W-1:0]    tbl_key [htfi_pkg::HT_SLOTS];
  logic [htfi_pkg::HANDLE_W-1:0] tbl_handle [htfi_pkg::HT_SLOTS];
  logic [htfi_pkg::OCC_W-1:0]    tbl_fill;
  logic [htfi_pkg::KEY_W-1:0]    stored_keys [$];
  htfi_pkg::res_t                pending_res [$];
  htfi_pkg::res_t                oldest;
  int unsigned                   n_errors = 0;
  int unsigned                   cycles = 0;

  hash_table_find_or_insert_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Find-or-insert on the shadow table, updating it as the block should.
  function automatic htfi_pkg::res_t find_or_insert(
      input logic [htfi_pkg::KEY_W-1:0] key,
      input logic [htfi_pkg::HANDLE_W-1:0] nh);
    htfi_pkg::res_t r;
    int unsigned pos;
    r = '{handle: '0, slot: '0, status: htfi_pkg::ST_FULL, occupied: '0};
    if (key == '0) begin
      r.status = htfi_pkg::ST_ZERO_KEY;
    end else begin
      pos = key % htfi_pkg::HT_SLOTS;
      for (int unsigned step = 0; step < htfi_pkg::HT_SLOTS; step++) begin
        if (tbl_key[pos] == key) begin
          r.handle = tbl_handle[pos];
          r.slot   = htfi_pkg::SLOT_W'(pos);
          r.status = htfi_pkg::ST_FOUND;
          break;
        end
        if (tbl_key[pos] == '0) begin
          tbl_key[pos]    = key;
          tbl_handle[pos] = nh;
          tbl_fill        = tbl_fill + 1'b1;
          stored_keys.push_back(key);
          r.handle = nh;
          r.slot   = htfi_pkg::SLOT_W'(pos);
          r.status = htfi_pkg::ST_INSERTED;
          break;
        end
        pos = (pos + step + 1) % htfi_pkg::HT_SLOTS;
      end
    end
    r.occupied = tbl_fill;
    return r;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [htfi_pkg::HANDLE_W-1:0] got,
                                 input logic [htfi_pkg::HANDLE_W-1:0] want);
    n_errors++;
    $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
             what, cycles, got, want);
  endtask

  // Presents one request beat and returns at the edge that accepts it.
  task automatic issue_request(input htfi_pkg::req_t rq, input logic typed,
                               input htfi_pkg::res_t typed_res);
    htfi_pkg::res_t predicted;
    req_i   <= rq;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    predicted = find_or_insert(rq.key, rq.new_handle);
    pending_res.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result beat", res_o.handle, '0);
      end else begin
        oldest = pending_res.pop_front();
        if (res_o.handle !== oldest.handle)
          report_mismatch("handle", res_o.handle, oldest.handle);
        if (res_o.slot !== oldest.slot)
          report_mismatch("slot", 64'(res_o.slot), 64'(oldest.slot));
        if (res_o.status !== oldest.status)
          report_mismatch("status", 64'(res_o.status), 64'(oldest.status));
        if (res_o.occupied !== oldest.occupied)
          report_mismatch("occupied", 64'(res_o.occupied), 64'(oldest.occupied));
      end
    end
  end

  initial begin
    htfi_pkg::req_t rq;
    int   burst_left;
    int   gap;
    int   pick;

    for (int i = 0; i < htfi_pkg::HT_SLOTS; i++) begin
      tbl_key[i]    = '0;
      tbl_handle[i] = '0;
    end
    tbl_fill   = '0;
    burst_left = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      issue_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Hold off once until the unit has drained completely.
      if (n == RAND_ITEMS / 2) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (pending_res.size() != 0);
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
      end
      burst_left--;

      // Mix of repeats, keys crowding a few home slots (long probe chains),
      // fully random keys and zero keys.
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        rq.key = '0;
      end else if (pick < 50 && stored_keys.size() > 0) begin
        rq.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (pick < 72) begin
        rq.key      = $urandom;
        rq.key[5:0] = 6'($urandom_range(0, 3) * 21);
        if (rq.key == '0) rq.key[31] = 1'b1;
      end else begin
        rq.key = $urandom;
      end
      case ($urandom_range(0, 9))
        0: rq.new_handle = '0;
        1: rq.new_handle = '1;
        default: rq.new_handle = {$urandom, $urandom};
      endcase
      issue_request(rq, 1'b0, '0);
    end

    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
    repeat (htfi_pkg::HT_SLOTS + 8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
